// File: design/frr_pkg.sv
// Shared types and constants for the fence sequence retire ring.
package frr_pkg;

  localparam int unsigned LOG_DEPTH_DEF = 5;

  localparam int unsigned WORD_W    = 32;
  localparam int unsigned IN_DATA_W = 96;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CONSERVATIVE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_NUMBER = 1'b1;

  // Input word kinds carried on in_tuser
  localparam logic MODE_PUT  = 1'b0;
  localparam logic MODE_POLL = 1'b1;

  typedef enum logic {
    ST_IDLE,
    ST_RETIRE
  } frr_state_t;

endpackage

// File: design/fence_sequence_retire_ring.sv
// Top level of the fence sequence retire ring: ring storage, retire sequencer, result register.
//
// A put that finds room in the ring is stored on acceptance and answered through the result register.
// A poll, or a put that finds the ring full, walks the ring from the tail with one
// 32-bit unsigned compare per cycle against the supplied hardware count: it retires
// entries in order from the tail until an entry's fence exceeds the count or the ring
// is empty, then stores a full-ring put if room was made and answers. The pace is set
// by the single registered read port of the pair memory, which presents one tail entry
// per cycle. Input is not taken while a walk runs or while a result waits unclaimed.
// The ring holds 2^LOG_DEPTH - 1 pairs; storage needs no clearing after reset.
module fence_sequence_retire_ring
  import frr_pkg::*;
#(
  parameter int unsigned LOG_DEPTH = LOG_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,  // number, fence_value, hw_count
  input  logic                  in_tuser,  // mode
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata, // last_number, busy_res, accepted, zero pad
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [WORD_W-1:0]     cfg_wdata
);

  localparam int unsigned DEPTH = 1 << LOG_DEPTH;
  localparam int unsigned PAD_W = OUT_DATA_W - WORD_W - 2;

  logic [2*WORD_W-1:0] mem [DEPTH];

  frr_state_t          state_r, state_nxt;
  logic [LOG_DEPTH-1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [WORD_W-1:0]   last_r, last_nxt, prev_r, prev_nxt;
  logic                cons_r, cons_nxt;
  logic                was_empty_r, was_empty_nxt;
  logic                mode_r, mode_nxt;
  logic [WORD_W-1:0]   num_r, num_nxt, fence_r, fence_nxt, hw_r, hw_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [2*WORD_W-1:0] rd_data_r;

  logic                wr_en;
  logic [2*WORD_W-1:0] wr_data;
  logic                in_fire;
  logic [LOG_DEPTH-1:0] head_inc;
  logic [WORD_W-1:0]   in_num, in_fence, in_hw, rd_fence, rd_num, last_fin;
  logic                stop;
  logic                acc;

  assign in_num   = in_tdata[WORD_W-1:0];
  assign in_fence = in_tdata[2*WORD_W-1:WORD_W];
  assign in_hw    = in_tdata[3*WORD_W-1:2*WORD_W];
  assign rd_num   = rd_data_r[WORD_W-1:0];
  assign rd_fence = rd_data_r[2*WORD_W-1:WORD_W];
  assign head_inc = head_r + LOG_DEPTH'(1);

  assign in_tready  = (state_r == ST_IDLE) && (!out_valid_r || out_tready);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    last_nxt      = last_r;
    prev_nxt      = prev_r;
    cons_nxt      = cons_r;
    was_empty_nxt = was_empty_r;
    mode_nxt      = mode_r;
    num_nxt       = num_r;
    fence_nxt     = fence_r;
    hw_nxt        = hw_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    wr_en         = 1'b0;
    wr_data       = {fence_r, num_r};
    stop          = 1'b0;
    acc           = 1'b0;
    last_fin      = last_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          mode_nxt      = in_tuser;
          num_nxt       = in_num;
          fence_nxt     = in_fence;
          hw_nxt        = in_hw;
          was_empty_nxt = (head_r == tail_r);
          if (in_tuser == MODE_PUT && head_inc != tail_r) begin
            // room in the ring: store and answer at once
            wr_en         = 1'b1;
            wr_data       = {in_fence, in_num};
            head_nxt      = head_inc;
            out_valid_nxt = 1'b1;
            out_data_nxt  = {PAD_W'(0), 1'b1, 1'b1, last_r};
          end else begin
            state_nxt = ST_RETIRE;
          end
        end
      end
      ST_RETIRE: begin
        stop = (tail_r == head_r) || (hw_r < rd_fence);
        if (!stop) begin
          // retire the tail entry; memory presents the next one next cycle
          if (cons_r) begin
            last_nxt = prev_r;
            prev_nxt = rd_num;
          end else begin
            last_nxt = rd_num;
          end
          tail_nxt = tail_r + LOG_DEPTH'(1);
        end else begin
          if (cons_r && was_empty_r && last_r != prev_r) begin
            last_fin = prev_r;
          end
          last_nxt = last_fin;
          if (mode_r == MODE_PUT && head_inc != tail_r) begin
            wr_en    = 1'b1;
            head_nxt = head_inc;
            acc      = 1'b1;
          end
          out_valid_nxt = 1'b1;
          out_data_nxt  = {PAD_W'(0), acc, (head_nxt != tail_r), last_fin};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CONSERVATIVE: cons_nxt = cfg_wdata[0];
        CFG_INITIAL_NUMBER: begin
          head_nxt = '0;
          tail_nxt = '0;
          last_nxt = cfg_wdata;
          prev_nxt = cfg_wdata;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      last_r      <= '0;
      prev_r      <= '0;
      cons_r      <= 1'b0;
      was_empty_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      last_r      <= last_nxt;
      prev_r      <= prev_nxt;
      cons_r      <= cons_nxt;
      was_empty_r <= was_empty_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    num_r      <= num_nxt;
    fence_r    <= fence_nxt;
    hw_r       <= hw_nxt;
    out_data_r <= out_data_nxt;
  end

  // pair memory: write at head, registered read follows the next tail
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[head_r] <= wr_data;
    end
    rd_data_r <= mem[tail_nxt];
  end

endmodule

// File: design/frr_checker.sv
// Port-level checker for the fence sequence retire ring, bound to the top level.
module frr_checker
  import frr_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // a stored put leaves at least one entry in the ring
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[WORD_W+1] |-> out_tdata[WORD_W])
    else $error("accepted put reported an empty ring");

  // a waiting result blocks new input words
  a_slot_block: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while result slot is full");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind fence_sequence_retire_ring frr_checker u_frr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: sim/tb_fence_sequence_retire_ring.sv
// Self-checking testbench for the fence sequence retire ring: directed table plus random put/poll traffic.
module tb_fence_sequence_retire_ring;
  timeunit 1ns;
  timeprecision 1ps;
  import frr_pkg::*;

  localparam int unsigned RING         = 1 << LOG_DEPTH_DEF;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned RANDOM_ITEMS = 1130;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned REPORT_MAX   = 10;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum logic [1:0] {ROW_PUT, ROW_POLL, ROW_CFG_CONS, ROW_CFG_INIT} row_kind_t;

  typedef struct packed {
    logic              mode;
    logic [WORD_W-1:0] number;
    logic [WORD_W-1:0] fence;
    logic [WORD_W-1:0] hw;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] last_number;
    logic              busy;
    logic              accepted;
  } result_t;

  // put: a = number, b = fence, c = hw count; poll: c = hw count; register rows: b = value
  typedef struct packed {
    row_kind_t         kind;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] c;
    logic              typed;
    result_t           want;
  } dir_row_t;

  localparam result_t NO_CHECK = '0;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // number, fence_value, hw_count
  logic                  in_tuser   = MODE_PUT;  // mode
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // last_number, busy_res, accepted, zero pad
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = CFG_CONSERVATIVE;
  logic [WORD_W-1:0]     cfg_wdata  = '0;

  // Predictor state
  logic [WORD_W-1:0]        fence_ring  [RING];
  logic [WORD_W-1:0]        number_ring [RING];
  logic [LOG_DEPTH_DEF-1:0] head_q      = '0;
  logic [LOG_DEPTH_DEF-1:0] tail_q      = '0;
  logic [WORD_W-1:0]        done_q      = '0;
  logic [WORD_W-1:0]        prev_done_q = '0;
  logic                     cons_q      = 1'b0;

  result_t completions_due [$];
  int      mismatches   = 0;
  int      quiet_cycles = 0;
  int      send_pct     = 0;
  int      stall_pct    = 0;

  dir_row_t plan [0:23] = '{
    '{ROW_POLL,     32'h0,         32'h0,         32'h0,         1'b1, '{32'h0, 1'b0, 1'b0}},
    '{ROW_PUT,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,         1'b1, '{32'h0, 1'b1, 1'b1}},
    '{ROW_POLL,     32'h0,         32'h0,         32'hFFFF_FFFE, 1'b1, '{32'h0, 1'b1, 1'b0}},
    '{ROW_POLL,     32'h0,         32'h0,         32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{ROW_PUT,      32'd1,         32'd10,        32'h0,         1'b0, NO_CHECK},
    '{ROW_PUT,      32'd2,         32'd20,        32'h0,         1'b0, NO_CHECK},
    '{ROW_PUT,      32'd3,         32'd30,        32'h0,         1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'd25,        1'b0, NO_CHECK},
    '{ROW_CFG_CONS, 32'h0,         32'h1,         32'h0,         1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'd30,        1'b0, NO_CHECK},
    // empty ring with the lagging number behind: catch up
    '{ROW_POLL,     32'h0,         32'h0,         32'h0,         1'b0, NO_CHECK},
    '{ROW_CFG_INIT, 32'h0,         32'hFFFF_FFFF, 32'h0,         1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'h0,         1'b1,
      '{32'hFFFF_FFFF, 1'b0, 1'b0}},
    '{ROW_PUT,      32'd5,         32'h8000_0000, 32'h0,         1'b0, NO_CHECK},
    '{ROW_PUT,      32'd6,         32'h8000_0001, 32'h0,         1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'h8000_0000, 1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'h7FFF_FFFF, 1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'hFFFF_FFFF, 1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'h0,         1'b0, NO_CHECK},
    '{ROW_CFG_CONS, 32'h0,         32'h0,         32'h0,         1'b0, NO_CHECK},
    '{ROW_CFG_INIT, 32'h0,         32'h0,         32'h0,         1'b0, NO_CHECK},
    '{ROW_PUT,      32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0,         1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'h5A5A_5A59, 1'b0, NO_CHECK},
    '{ROW_POLL,     32'h0,         32'h0,         32'h5A5A_5A5A, 1'b0, NO_CHECK}
  };

  fence_sequence_retire_ring uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Retire from the tail while the hardware count has reached the fence.
  function automatic void walk_tail(input logic [WORD_W-1:0] hw);
    logic was_empty;
    logic halt;
    was_empty = (head_q == tail_q);
    halt      = 1'b0;
    while (!halt && tail_q != head_q) begin
      if (hw < fence_ring[tail_q]) begin
        halt = 1'b1;
      end else begin
        if (cons_q) begin
          done_q      = prev_done_q;
          prev_done_q = number_ring[tail_q];
        end else begin
          done_q = number_ring[tail_q];
        end
        tail_q = tail_q + 1'b1;
      end
    end
    if (cons_q && was_empty && done_q != prev_done_q) done_q = prev_done_q;
  endfunction

  function automatic result_t completion_after(input item_t it);
    logic [LOG_DEPTH_DEF-1:0] nxt;
    result_t                  r;
    r.accepted = 1'b0;
    if (it.mode == MODE_PUT) begin
      nxt = head_q + 1'b1;
      if (nxt == tail_q) walk_tail(it.hw);
      if (nxt != tail_q) begin
        fence_ring[head_q]  = it.fence;
        number_ring[head_q] = it.number;
        head_q              = nxt;
        r.accepted          = 1'b1;
      end
    end else begin
      walk_tail(it.hw);
    end
    r.last_number = done_q;
    r.busy        = (head_q != tail_q);
    return r;
  endfunction

  // Move the hardware count toward the newest issued fence.
  function automatic logic [WORD_W-1:0] hw_step(input logic [WORD_W-1:0] hw,
                                                input logic [WORD_W-1:0] top);
    logic [WORD_W-1:0] lag;
    logic [WORD_W-1:0] step;
    lag  = top - hw;
    step = $urandom_range(0, 12);
    if ($urandom_range(4) == 0 || step > lag) return top;
    return hw + step;
  endfunction

  task automatic send_word(input item_t it, input logic typed, input result_t want);
    result_t due;
    in_tvalid <= 1'b1;
    in_tuser  <= it.mode;
    in_tdata  <= {it.hw, it.fence, it.number};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    due = completion_after(it);
    completions_due.push_back(typed ? want : due);
    if (send_pct != 0 && $urandom_range(99) < send_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
  endtask

  // Registers change only with the ring idle: drain all results first.
  task automatic write_reg(input row_kind_t which, input logic [WORD_W-1:0] value);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (completions_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= (which == ROW_CFG_CONS) ? CFG_CONSERVATIVE : CFG_INITIAL_NUMBER;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (which == ROW_CFG_CONS) begin
      cons_q = value[0];
    end else begin
      head_q      = '0;
      tail_q      = '0;
      done_q      = value;
      prev_done_q = value;
    end
    @(posedge clk);
  endtask

  always @(posedge clk) begin : check_results
    result_t got;
    result_t due;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.last_number = out_tdata[WORD_W-1:0];
        got.busy        = out_tdata[WORD_W];
        got.accepted    = out_tdata[WORD_W+1];
        if (completions_due.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("completion word with nothing expected: last %h busy %b accepted %b",
                     got.last_number, got.busy, got.accepted);
        end else begin
          due = completions_due.pop_front();
          if (got.last_number !== due.last_number || got.busy !== due.busy ||
              got.accepted !== due.accepted) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("completion mismatch: expected last %h busy %b accepted %b, got %h %b %b",
                       due.last_number, due.busy, due.accepted,
                       got.last_number, got.busy, got.accepted);
          end
        end
      end
      out_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    item_t             it;
    idle_mode_t        idle;
    logic              cons;
    logic              init_on;
    logic [WORD_W-1:0] init_val;
    logic [WORD_W-1:0] issued;
    logic [WORD_W-1:0] hw_now;
    int                sent;
    int                n_puts;
    int                n_polls;
    issued = '0;
    hw_now = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pct  = 27;
    stall_pct = 27;
    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_PUT, ROW_POLL: begin
          it.mode   = (plan[i].kind == ROW_PUT) ? MODE_PUT : MODE_POLL;
          it.number = plan[i].a;
          it.fence  = plan[i].b;
          it.hw     = plan[i].c;
          send_word(it, plan[i].typed, plan[i].want);
        end
        default: write_reg(plan[i].kind, plan[i].b);
      endcase
    end

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin idle = IDLE_NONE; cons = 1'b0; init_on = 1'b1; init_val = '0; end
        1:       begin idle = IDLE_SEND; cons = 1'b1; init_on = 1'b1; init_val = '1; end
        2:       begin idle = IDLE_RECV; cons = 1'b1; init_on = 1'b0; init_val = '0; end
        3:       begin idle = IDLE_BOTH; cons = 1'b0; init_on = 1'b1; init_val = $urandom; end
        4:       begin idle = IDLE_SEND; cons = 1'b1; init_on = 1'b1; init_val = $urandom; end
        default: begin idle = IDLE_BOTH; cons = 1'b0; init_on = 1'b0; init_val = '0; end
      endcase
      write_reg(ROW_CFG_CONS, {31'b0, cons});
      if (init_on) begin
        write_reg(ROW_CFG_INIT, init_val);
        // one phase runs the fence counter across the 32-bit wrap
        issued = (p == 3) ? 32'hFFFF_FF00 : $urandom;
        hw_now = issued;
      end
      send_pct  = (idle == IDLE_SEND) ? 62 : (idle == IDLE_BOTH) ? 27 : 0;
      stall_pct = (idle == IDLE_RECV) ? 62 : (idle == IDLE_BOTH) ? 27 : 0;
      sent = 0;
      while (sent < RANDOM_ITEMS / PHASES) begin
        if ($urandom_range(99) < 75) begin
          // submission burst, long enough now and then to fill the ring
          n_puts = ($urandom_range(3) == 0) ? $urandom_range(28, 40) : $urandom_range(1, 8);
          repeat (n_puts) begin
            issued = issued + $urandom_range(1, 4);
            if ($urandom_range(3) == 0) hw_now = hw_step(hw_now, issued);
            it = '{MODE_PUT, $urandom, issued, hw_now};
            send_word(it, 1'b0, NO_CHECK);
            sent++;
          end
          n_polls = $urandom_range(1, 3);
          repeat (n_polls) begin
            hw_now = hw_step(hw_now, issued);
            it = '{MODE_POLL, $urandom, $urandom, hw_now};
            send_word(it, 1'b0, NO_CHECK);
            sent++;
          end
        end else begin
          repeat ($urandom_range(1, 3)) begin
            it.mode   = ($urandom_range(2) == 0) ? MODE_PUT : MODE_POLL;
            it.number = $urandom;
            it.fence  = $urandom;
            it.hw     = $urandom;
            send_word(it, 1'b0, NO_CHECK);
            sent++;
          end
        end
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (completions_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && completions_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
